// ===== rtl/cht_pkg.sv =====
// Package with the shared types and codes of the cuckoo hash table.
`default_nettype none
package cht_pkg;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [31:0] key;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [1:0]  which_table;
      logic [9:0]  slot;
      logic [31:0] homeless_key;
   } rsp_type;

   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_LOOKUP = 2'd1;
   localparam logic [1:0] OP_REMOVE = 2'd2;

   localparam logic [2:0] ST_INSERTED  = 3'd0;
   localparam logic [2:0] ST_PRESENT   = 3'd1;
   localparam logic [2:0] ST_FOUND     = 3'd2;
   localparam logic [2:0] ST_NOT_FOUND = 3'd3;
   localparam logic [2:0] ST_REMOVED   = 3'd4;
   localparam logic [2:0] ST_FAILED    = 3'd5;
   localparam logic [2:0] ST_INVALID   = 3'd6;

   localparam logic [1:0] TBL_NONE   = 2'd0;
   localparam logic [1:0] TBL_FIRST  = 2'd1;
   localparam logic [1:0] TBL_SECOND = 2'd2;

   localparam logic [3:0] CSR_TABLE_SIZE = 4'd0;
   localparam logic [3:0] CSR_MAX_LOOP   = 4'd1;

endpackage
`default_nettype wire

// ===== rtl/cuckoo_hash_table.sv =====
// Top level of the two-table cuckoo hash set: sequencer, registers and tables.
// After reset the block sweeps every slot of both tables to empty with busy high.
// Every hash of a request then goes through one shared bit-serial remainder unit.
// A lookup or remove computes both hashes in turn and then reads both tables. An
// insert of a new key adds displacement rounds (up to max_loop rounds), each moving
// keys into the first and then the second table, then reads both tables to locate the key.
// busy stays high for the whole of a valid request; a request with a zero key or an
// unknown opcode is answered on the next cycle and busy stays low.
// The single result appears on rsp_data with rsp_valid high for exactly one cycle
// and must be taken then.
`default_nettype none
module cuckoo_hash_table #(
   parameter int SLOTS    = 1024,
   parameter int KEY_BITS = 32
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            start,
   input  wire cht_pkg::req_type req_data,
   output logic                 busy,
   output logic                 rsp_valid,
   output cht_pkg::rsp_type     rsp_data,
   input  wire logic            csr_valid,
   output logic                 csr_ready,
   input  wire logic [3:0]      csr_index,
   input  wire logic [31:0]     csr_data
);
   localparam int IW = $clog2(SLOTS);
   localparam int DW = $clog2(SLOTS + 1);

   localparam logic [3:0] S_CLEAR = 4'd0;
   localparam logic [3:0] S_IDLE  = 4'd1;
   localparam logic [3:0] S_KA    = 4'd2;
   localparam logic [3:0] S_KB    = 4'd3;
   localparam logic [3:0] S_KCMP  = 4'd4;
   localparam logic [3:0] S_XA    = 4'd5;
   localparam logic [3:0] S_W1    = 4'd6;
   localparam logic [3:0] S_XB    = 4'd7;
   localparam logic [3:0] S_W2    = 4'd8;
   localparam logic [3:0] S_RELOC = 4'd9;

   logic [3:0]          state_ff, state_in;
   logic [IW-1:0]       clr_ff, clr_in;
   logic [1:0]          op_ff, op_in;
   logic [KEY_BITS-1:0] key_ff, key_in;
   logic [KEY_BITS-1:0] x_ff, x_in;
   logic [IW-1:0]       ka_ff, ka_in;
   logic [IW-1:0]       kb_ff, kb_in;
   logic [IW-1:0]       addr_ff, addr_in;
   logic [7:0]          round_ff, round_in;
   logic                post_ff, post_in;
   logic                placed_ff, placed_in;
   logic [10:0]         table_size_ff;
   logic [7:0]          max_loop_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   cht_pkg::rsp_type    rsp_ff, rsp_in;

   logic [DW-1:0]       eff;
   logic                mod_start, mod_minus, mod_done;
   logic [KEY_BITS-1:0] mod_num;
   logic [DW-1:0]       mod_den, mod_rem;

   logic                we1, we2, re1, re2;
   logic [IW-1:0]       waddr1, waddr2, raddr1, raddr2;
   logic [KEY_BITS-1:0] wdata1, wdata2, rd1, rd2;

   logic [KEY_BITS-1:0] req_key;
   logic                hit1, hit2;
   logic [1:0]          hit_tbl;
   logic [IW-1:0]       hit_pos;

   assign req_key = KEY_BITS'(req_data.key);

   // Clamp the table size to the range the tables support.
   always_comb begin
      if (table_size_ff < 11'd2) begin
         eff = DW'(2);
      end else if (32'(table_size_ff) > 32'(SLOTS)) begin
         eff = DW'(SLOTS);
      end else begin
         eff = DW'(table_size_ff);
      end
   end

   assign mod_den = mod_minus ? (eff - DW'(1)) : eff;

   cht_mod #(.KEY_BITS(KEY_BITS), .DW(DW)) u_mod (
      .clock (clock),
      .reset (reset),
      .start (mod_start),
      .num   (mod_num),
      .den   (mod_den),
      .done  (mod_done),
      .rem   (mod_rem)
   );

   cht_ram #(.DEPTH(SLOTS), .WIDTH(KEY_BITS)) u_first (
      .clock (clock),
      .we    (we1),
      .waddr (waddr1),
      .wdata (wdata1),
      .re    (re1),
      .raddr (raddr1),
      .rdata (rd1)
   );

   cht_ram #(.DEPTH(SLOTS), .WIDTH(KEY_BITS)) u_second (
      .clock (clock),
      .we    (we2),
      .waddr (waddr2),
      .wdata (wdata2),
      .re    (re2),
      .raddr (raddr2),
      .rdata (rd2)
   );

   assign hit1 = (rd1 == key_ff);
   assign hit2 = (rd2 == key_ff);

   always_comb begin
      if (hit1) begin
         hit_tbl = cht_pkg::TBL_FIRST;
         hit_pos = ka_ff;
      end else if (hit2) begin
         hit_tbl = cht_pkg::TBL_SECOND;
         hit_pos = kb_ff;
      end else begin
         hit_tbl = cht_pkg::TBL_NONE;
         hit_pos = '0;
      end
   end

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      op_in        = op_ff;
      key_in       = key_ff;
      x_in         = x_ff;
      ka_in        = ka_ff;
      kb_in        = kb_ff;
      addr_in      = addr_ff;
      round_in     = round_ff;
      post_in      = post_ff;
      placed_in    = placed_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      mod_start    = 1'b0;
      mod_minus    = 1'b0;
      mod_num      = key_ff;
      we1          = 1'b0;
      we2          = 1'b0;
      waddr1       = addr_ff;
      waddr2       = addr_ff;
      wdata1       = x_ff;
      wdata2       = x_ff;
      re1          = 1'b0;
      re2          = 1'b0;
      raddr1       = ka_ff;
      raddr2       = kb_ff;

      case (state_ff)
         S_CLEAR: begin
            we1    = 1'b1;
            we2    = 1'b1;
            waddr1 = clr_ff;
            waddr2 = clr_ff;
            wdata1 = '0;
            wdata2 = '0;
            clr_in = clr_ff + IW'(1);
            if (clr_ff == IW'(SLOTS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               if (req_key == '0 || !(req_data.opcode == cht_pkg::OP_INSERT ||
                   req_data.opcode == cht_pkg::OP_LOOKUP ||
                   req_data.opcode == cht_pkg::OP_REMOVE)) begin
                  rsp_valid_in        = 1'b1;
                  rsp_in.status       = cht_pkg::ST_INVALID;
                  rsp_in.which_table  = cht_pkg::TBL_NONE;
                  rsp_in.slot         = '0;
                  rsp_in.homeless_key = '0;
               end else begin
                  op_in     = req_data.opcode;
                  key_in    = req_key;
                  post_in   = 1'b0;
                  mod_start = 1'b1;
                  mod_num   = req_key;
                  state_in  = S_KA;
               end
            end
         end
         S_KA: begin
            if (mod_done) begin
               ka_in     = IW'(mod_rem);
               mod_start = 1'b1;
               mod_minus = 1'b1;
               state_in  = S_KB;
            end
         end
         S_KB: begin
            if (mod_done) begin
               kb_in    = IW'(mod_rem);
               re1      = 1'b1;
               re2      = 1'b1;
               raddr2   = IW'(mod_rem);
               state_in = S_KCMP;
            end
         end
         S_KCMP: begin
            rsp_in.which_table  = hit_tbl;
            rsp_in.slot         = 10'(hit_pos);
            rsp_in.homeless_key = '0;
            state_in            = S_IDLE;
            rsp_valid_in        = 1'b1;
            if (post_ff) begin
               post_in = 1'b0;
               if (placed_ff) begin
                  rsp_in.status = cht_pkg::ST_INSERTED;
               end else begin
                  rsp_in.status       = cht_pkg::ST_FAILED;
                  rsp_in.homeless_key = 32'(x_ff);
               end
            end else if (op_ff == cht_pkg::OP_LOOKUP) begin
               rsp_in.status = (hit1 || hit2) ? cht_pkg::ST_FOUND : cht_pkg::ST_NOT_FOUND;
            end else if (op_ff == cht_pkg::OP_REMOVE) begin
               rsp_in.status = (hit1 || hit2) ? cht_pkg::ST_REMOVED : cht_pkg::ST_NOT_FOUND;
               we1           = hit1;
               we2           = hit2 && !hit1;
               waddr1        = ka_ff;
               waddr2        = kb_ff;
               wdata1        = '0;
               wdata2        = '0;
            end else if (hit1 || hit2) begin
               rsp_in.status = cht_pkg::ST_PRESENT;
            end else if (max_loop_ff == 8'd0) begin
               // No rounds allowed: the new key itself is left without a home.
               rsp_in.status       = cht_pkg::ST_FAILED;
               rsp_in.homeless_key = 32'(key_ff);
            end else begin
               rsp_valid_in = 1'b0;
               x_in         = key_ff;
               round_in     = '0;
               placed_in    = 1'b0;
               mod_start    = 1'b1;
               mod_num      = key_ff;
               state_in     = S_XA;
            end
         end
         S_XA: begin
            if (mod_done) begin
               addr_in  = IW'(mod_rem);
               re1      = 1'b1;
               raddr1   = IW'(mod_rem);
               state_in = S_W1;
            end
         end
         S_W1: begin
            we1  = 1'b1;
            x_in = rd1;
            if (rd1 == '0) begin
               placed_in = 1'b1;
               state_in  = S_RELOC;
            end else begin
               mod_start = 1'b1;
               mod_minus = 1'b1;
               mod_num   = rd1;
               state_in  = S_XB;
            end
         end
         S_XB: begin
            if (mod_done) begin
               addr_in  = IW'(mod_rem);
               re2      = 1'b1;
               raddr2   = IW'(mod_rem);
               state_in = S_W2;
            end
         end
         S_W2: begin
            we2  = 1'b1;
            x_in = rd2;
            if (rd2 == '0) begin
               placed_in = 1'b1;
               state_in  = S_RELOC;
            end else if ({1'b0, round_ff} + 9'd1 >= {1'b0, max_loop_ff}) begin
               state_in = S_RELOC;
            end else begin
               round_in  = round_ff + 8'd1;
               mod_start = 1'b1;
               mod_num   = rd2;
               state_in  = S_XA;
            end
         end
         S_RELOC: begin
            // The key's own hashes are unchanged, so only the tables are read again.
            re1      = 1'b1;
            re2      = 1'b1;
            post_in  = 1'b1;
            state_in = S_KCMP;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         clr_ff        <= '0;
         post_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         table_size_ff <= 11'd1024;
         max_loop_ff   <= 8'd16;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         post_ff      <= post_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            if (csr_index == cht_pkg::CSR_TABLE_SIZE) begin
               table_size_ff <= csr_data[10:0];
            end else if (csr_index == cht_pkg::CSR_MAX_LOOP) begin
               max_loop_ff <= csr_data[7:0];
            end
         end
      end
      op_ff     <= op_in;
      key_ff    <= key_in;
      x_ff      <= x_in;
      ka_ff     <= ka_in;
      kb_ff     <= kb_in;
      addr_ff   <= addr_in;
      round_ff  <= round_in;
      placed_ff <= placed_in;
      rsp_ff    <= rsp_in;
   end

   assign busy      = (state_ff != S_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTH
   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy || rsp_valid))
      else $error("accepted request neither started nor answered");

   a_insert_located: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status == cht_pkg::ST_INSERTED) |->
      (rsp_data.which_table != cht_pkg::TBL_NONE))
      else $error("inserted key not found in either table");

   a_invalid_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status == cht_pkg::ST_INVALID) |->
      (rsp_data.which_table == cht_pkg::TBL_NONE && rsp_data.homeless_key == '0))
      else $error("invalid request reported a location or key");
`endif
endmodule
`default_nettype wire

// ===== rtl/cht_mod.sv =====
// Bit-serial remainder unit shared by both hash functions.
`default_nettype none
module cht_mod #(
   parameter int KEY_BITS = 32,
   parameter int DW       = 11
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   input  wire logic [KEY_BITS-1:0] num,
   input  wire logic [DW-1:0]       den,
   output logic                     done,
   output logic [DW-1:0]            rem
);
   localparam int CW = $clog2(KEY_BITS + 1);

   logic [CW-1:0]       cnt_ff, cnt_in;
   logic                done_ff, done_in;
   logic [DW-1:0]       r_ff, r_in;
   logic [DW-1:0]       den_ff, den_in;
   logic [KEY_BITS-1:0] q_ff, q_in;
   logic [DW:0]         trial;

   always_comb begin
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      r_in    = r_ff;
      den_in  = den_ff;
      q_in    = q_ff;
      trial   = {r_ff, q_ff[KEY_BITS-1]};
      if (start) begin
         cnt_in = CW'(KEY_BITS);
         r_in   = '0;
         den_in = den;
         q_in   = num;
      end else if (cnt_ff != '0) begin
         // One restoring step: bring in the next dividend bit, subtract if it fits.
         if (trial >= {1'b0, den_ff}) begin
            r_in = DW'(trial - {1'b0, den_ff});
         end else begin
            r_in = DW'(trial);
         end
         q_in    = {q_ff[KEY_BITS-2:0], 1'b0};
         cnt_in  = cnt_ff - CW'(1);
         done_in = (cnt_ff == CW'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      r_ff   <= r_in;
      den_ff <= den_in;
      q_ff   <= q_in;
   end

   assign done = done_ff;
   assign rem  = r_ff;
endmodule
`default_nettype wire

// ===== rtl/cht_ram.sv =====
// Single-write, single-read key table with registered read data.
`default_nettype none
module cht_ram #(
   parameter int DEPTH = 1024,
   parameter int WIDTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]              rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;
endmodule
`default_nettype wire
